FILE: src/jsph_pkg.sv
// shared constants, register map and types for the joystick position hold block
package jsph_pkg;

  localparam int TIME_W     = 32;
  localparam int JOY_W      = 8;
  localparam int LIM_W      = 12;
  localparam int RANGE_W    = LIM_W + 1;
  localparam int PROD1_W    = 19;
  localparam int NUM_W      = PROD1_W + TIME_W;
  localparam int TRAVEL_W   = 16;
  localparam int DEN_W      = TRAVEL_W + 7;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int NEXT_W     = NUM_W + 2;
  localparam int PWR_W      = 10;
  localparam int TGT_W      = 12;
  localparam int OUT_TDATA_W = ((2 * PWR_W + 2 * TGT_W + 7) / 8) * 8;

  localparam int CHECK_MS   = 100;
  localparam int JOY_FULL   = 127;
  localparam int POWER_CAP  = 100;
  localparam int RECIP9     = 233017;
  localparam int RECIP9_SH  = 21;
  localparam int ELBOW_SH   = 3;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_DEADBAND = 3'd0;
  localparam logic [2:0] REG_TRAVEL   = 3'd1;
  localparam logic [2:0] REG_SH_MIN   = 3'd2;
  localparam logic [2:0] REG_SH_MAX   = 3'd3;
  localparam logic [2:0] REG_EL_MIN   = 3'd4;
  localparam logic [2:0] REG_EL_MAX   = 3'd5;

  localparam logic [6:0]        DEADBAND_RST = 7'd15;
  localparam logic [TRAVEL_W-1:0] TRAVEL_RST = 16'd2000;
  localparam logic [LIM_W-1:0]  SH_MIN_RST   = 12'd625;
  localparam logic [LIM_W-1:0]  SH_MAX_RST   = 12'd3200;
  localparam logic [LIM_W-1:0]  EL_MIN_RST   = 12'd10;
  localparam logic [LIM_W-1:0]  EL_MAX_RST   = 12'd4000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/jsph_div.sv
// restoring divider, one quotient bit per cycle
module jsph_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [jsph_pkg::NUM_W-1:0]   num,
  input  logic [jsph_pkg::DEN_W-1:0]   den,
  output jsph_pkg::div_stat_t          stat,
  output logic [jsph_pkg::NUM_W-1:0]   quot,
  output logic [jsph_pkg::DEN_W-1:0]   rem
);
  import jsph_pkg::*;

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W-1:0] rem_step;

  always_comb begin
    shifted  = {rem_r, quot_r[NUM_W-1]};
    ge       = (shifted >= {1'b0, den_r});
    rem_step = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= rem_step;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;
  assign rem       = rem_r;

endmodule

FILE: src/joystick_setpoint_position_hold.sv
// a start item or a tick without a setpoint move passes CHECK, POWER and FINAL; out_tvalid is registered
// a tick that moves setpoints adds MUL1, MUL2, DIV_WAIT, FIX and CLAMP, using the 51-step shared divider
// (one pass per axis; an axis inside the deadband skips its pass)
// one item at a time: in_tready is high only while the sequencer is idle
// reset: synchronous rst_n clears setpoints, check time and control, loads register defaults
module joystick_setpoint_position_hold #(
  parameter int POT_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: now_ms, fine_mode, joy_shoulder, joy_elbow, pot_shoulder, pot_elbow
  input  logic [((jsph_pkg::TIME_W + 1 + 2*jsph_pkg::JOY_W + 2*POT_BITS + 7)/8)*8-1:0] in_tdata,
  // in_tuser: action
  input  logic in_tuser,
  input  logic in_tvalid,
  output logic in_tready,
  // out_tdata: shoulder_power, elbow_power, shoulder_target, elbow_target
  output logic [jsph_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [jsph_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [jsph_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [jsph_pkg::CFG_DW-1:0] cfg_prdata,
  output logic cfg_pready
);
  import jsph_pkg::*;

  localparam int IN_W = TIME_W + 1 + 2 * JOY_W + 2 * POT_BITS;
  localparam int PW   = POT_BITS + 2;
  localparam int PM_W = POT_BITS + RECIP9_SH;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CHECK    = 4'd1;
  localparam logic [3:0] ST_MUL1     = 4'd2;
  localparam logic [3:0] ST_MUL2     = 4'd3;
  localparam logic [3:0] ST_DIV_WAIT = 4'd4;
  localparam logic [3:0] ST_FIX      = 4'd5;
  localparam logic [3:0] ST_CLAMP    = 4'd6;
  localparam logic [3:0] ST_POWER    = 4'd7;
  localparam logic [3:0] ST_FINAL    = 4'd8;

  // configuration registers
  logic [6:0]          deadband_r;
  logic [TRAVEL_W-1:0] travel_r;
  logic [LIM_W-1:0]    sh_min_r, sh_max_r, el_min_r, el_max_r;

  // state
  logic [3:0]          state_r, state_nxt;
  logic [TIME_W-1:0]   last_check_r;
  logic [POT_BITS-1:0] set_s_r, set_e_r;

  // request fields
  logic                action_r;
  logic [TIME_W-1:0]   now_r;
  logic                fine_r;
  logic [JOY_W-1:0]    joy_s_r, joy_e_r;
  logic [POT_BITS-1:0] pot_s_r, pot_e_r;

  // work registers
  logic [TIME_W-1:0]        elapsed_r;
  logic [DEN_W-1:0]         den_r;
  logic                     axis_r;
  logic                     neg_r;
  logic [PROD1_W-1:0]       prod1_r;
  logic signed [NEXT_W-1:0] next_r;
  logic [PM_W-1:0]          pmul_r;
  logic                     neg_ps_r;
  logic signed [PW-1:0]     pwr_e_r;

  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  // config port
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
      travel_r   <= TRAVEL_RST;
      sh_min_r   <= SH_MIN_RST;
      sh_max_r   <= SH_MAX_RST;
      el_min_r   <= EL_MIN_RST;
      el_max_r   <= EL_MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEADBAND: deadband_r <= cfg_pwdata[6:0];
        REG_TRAVEL:   travel_r   <= cfg_pwdata[TRAVEL_W-1:0];
        REG_SH_MIN:   sh_min_r   <= cfg_pwdata[LIM_W-1:0];
        REG_SH_MAX:   sh_max_r   <= cfg_pwdata[LIM_W-1:0];
        REG_EL_MIN:   el_min_r   <= cfg_pwdata[LIM_W-1:0];
        REG_EL_MAX:   el_max_r   <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEADBAND: cfg_prdata = CFG_DW'(deadband_r);
      REG_TRAVEL:   cfg_prdata = CFG_DW'(travel_r);
      REG_SH_MIN:   cfg_prdata = CFG_DW'(sh_min_r);
      REG_SH_MAX:   cfg_prdata = CFG_DW'(sh_max_r);
      REG_EL_MIN:   cfg_prdata = CFG_DW'(el_min_r);
      REG_EL_MAX:   cfg_prdata = CFG_DW'(el_max_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // handshakes
  logic in_acc, out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_load   = (state_r == ST_FINAL) & (~out_valid_r | out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared divider
  jsph_pkg::div_stat_t div_stat;
  logic                div_start;
  logic [NUM_W-1:0]    prod2;
  logic [NUM_W-1:0]    div_quot;
  logic [DEN_W-1:0]    div_rem;

  assign div_start = (state_r == ST_MUL2);
  assign prod2     = NUM_W'(prod1_r) * NUM_W'(elapsed_r);

  jsph_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod2),
    .den   (den_r),
    .stat  (div_stat),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // per-axis datapath
  logic [JOY_W-1:0]         joy_sel, joy_mag;
  logic [LIM_W-1:0]         lo_sel, hi_sel;
  logic [POT_BITS-1:0]      set_sel;
  logic [RANGE_W-1:0]       rng;
  logic [LIM_W-1:0]         rng_mag;
  logic [PROD1_W:0]         prod1;
  logic                     neg_num;
  logic                     in_band;
  logic [TIME_W-1:0]        elapsed;
  logic [TRAVEL_W-1:0]      travel1;
  logic [NUM_W:0]           dmag;
  logic signed [NEXT_W-1:0] next_fix;
  logic signed [NEXT_W-1:0] lo_ext, hi_ext, clamp_val;

  always_comb begin
    joy_sel = axis_r ? joy_e_r : joy_s_r;
    lo_sel  = axis_r ? el_min_r : sh_min_r;
    hi_sel  = axis_r ? el_max_r : sh_max_r;
    set_sel = axis_r ? set_e_r : set_s_r;
    // -128 gives magnitude 128, still fits unsigned
    joy_mag = joy_sel[JOY_W-1] ? (~joy_sel + 1'b1) : joy_sel;
    in_band = ({1'b0, joy_mag} <= {2'b0, deadband_r});
    rng     = {1'b0, hi_sel} - {1'b0, lo_sel};
    rng_mag = rng[RANGE_W-1] ? LIM_W'(~rng + 1'b1) : rng[LIM_W-1:0];
    prod1   = (PROD1_W+1)'(joy_mag) * (PROD1_W+1)'(rng_mag);
    // sign of -joy * range
    neg_num = (~joy_sel[JOY_W-1] & (|joy_sel)) ^ rng[RANGE_W-1];
    elapsed = now_r - last_check_r;
    travel1 = (travel_r == '0) ? TRAVEL_W'(1) : travel_r;
    // floor of a negative quotient rounds the magnitude up
    dmag     = (NUM_W+1)'(div_quot) + (NUM_W+1)'(neg_r & (|div_rem));
    next_fix = neg_r ? ($signed(NEXT_W'(set_sel)) - $signed(NEXT_W'(dmag)))
                     : ($signed(NEXT_W'(set_sel)) + $signed(NEXT_W'(dmag)));
    lo_ext   = $signed(NEXT_W'(lo_sel));
    hi_ext   = $signed(NEXT_W'(hi_sel));
    clamp_val = next_r;
    if (clamp_val < lo_ext) begin
      clamp_val = lo_ext;
    end
    if (clamp_val > hi_ext) begin
      clamp_val = hi_ext;
    end
  end

  // power datapath
  logic signed [POT_BITS:0] ds, de;
  logic [POT_BITS-1:0]      ds_mag, de_mag, qe, q9;
  logic signed [PW-1:0]     pwr_e, pwr_s, pwr_s_cap, pwr_e_cap;
  logic [POT_BITS+TGT_W-1:0] tgt_s_ext, tgt_e_ext;

  always_comb begin
    ds     = $signed({1'b0, pot_s_r}) - $signed({1'b0, set_s_r});
    de     = $signed({1'b0, set_e_r}) - $signed({1'b0, pot_e_r});
    ds_mag = ds[POT_BITS] ? POT_BITS'(-ds) : ds[POT_BITS-1:0];
    de_mag = de[POT_BITS] ? POT_BITS'(-de) : de[POT_BITS-1:0];
    qe     = de_mag >> ELBOW_SH;
    pwr_e  = de[POT_BITS] ? -$signed(PW'(qe)) : $signed(PW'(qe));
    // reciprocal multiply gives floor(|d|/9) exactly for |d| below 2^21
    q9     = pmul_r[PM_W-1:RECIP9_SH];
    pwr_s  = neg_ps_r ? -$signed(PW'(q9)) : $signed(PW'(q9));
    pwr_s_cap = (pwr_s > $signed(PW'(POWER_CAP))) ? $signed(PW'(POWER_CAP)) : pwr_s;
    pwr_e_cap = (pwr_e_r > $signed(PW'(POWER_CAP))) ? $signed(PW'(POWER_CAP)) : pwr_e_r;
    tgt_s_ext = {{TGT_W{1'b0}}, set_s_r};
    tgt_e_ext = {{TGT_W{1'b0}}, set_e_r};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!action_r && fine_r && (elapsed > TIME_W'(CHECK_MS))) begin
          state_nxt = ST_MUL1;
        end else begin
          state_nxt = ST_POWER;
        end
      end
      ST_MUL1:     state_nxt = in_band ? ST_CLAMP : ST_MUL2;
      ST_MUL2:     state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = ST_FIX;
      ST_FIX:      state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = axis_r ? ST_POWER : ST_MUL1;
      ST_POWER:    state_nxt = ST_FINAL;
      ST_FINAL:    if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_check_r <= '0;
      set_s_r      <= '0;
      set_e_r      <= '0;
      axis_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CHECK: begin
          axis_r <= 1'b0;
          if (action_r) begin
            set_s_r <= pot_s_r;
            set_e_r <= pot_e_r;
          end else if (fine_r && (elapsed > TIME_W'(CHECK_MS))) begin
            last_check_r <= now_r;
          end
        end
        ST_CLAMP: begin
          if (axis_r) begin
            set_e_r <= clamp_val[POT_BITS-1:0];
          end else begin
            set_s_r <= clamp_val[POT_BITS-1:0];
          end
          axis_r <= ~axis_r;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_tuser;
      now_r    <= in_tdata[TIME_W-1:0];
      fine_r   <= in_tdata[TIME_W];
      joy_s_r  <= in_tdata[TIME_W+1 +: JOY_W];
      joy_e_r  <= in_tdata[TIME_W+1+JOY_W +: JOY_W];
      pot_s_r  <= in_tdata[TIME_W+1+2*JOY_W +: POT_BITS];
      pot_e_r  <= in_tdata[IN_W-POT_BITS +: POT_BITS];
    end
    if (state_r == ST_CHECK) begin
      elapsed_r <= elapsed;
      den_r     <= DEN_W'(travel1) * DEN_W'(JOY_FULL);
    end
    if (state_r == ST_MUL1) begin
      prod1_r <= prod1[PROD1_W-1:0];
      neg_r   <= neg_num;
      next_r  <= $signed(NEXT_W'(set_sel));
    end
    if (state_r == ST_FIX) begin
      next_r <= next_fix;
    end
    if (state_r == ST_POWER) begin
      pmul_r   <= PM_W'(ds_mag) * PM_W'(RECIP9);
      neg_ps_r <= ds[POT_BITS];
      pwr_e_r  <= pwr_e;
    end
    if (out_load) begin
      out_data_r <= OUT_TDATA_W'({tgt_e_ext[TGT_W-1:0], tgt_s_ext[TGT_W-1:0],
                                  pwr_e_cap[PWR_W-1:0], pwr_s_cap[PWR_W-1:0]});
    end
  end

endmodule

FILE: src/jsph_checker.sv
// port-level checks for the joystick position hold block, bound to the top level
module jsph_checker #(
  parameter int POT_BITS = 12
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [jsph_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import jsph_pkg::*;

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("outputs not idle after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still in work");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  a_power_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (POT_BITS > 12) ||
                   (($signed(out_tdata[PWR_W-1:0]) <= $signed(PWR_W'(POWER_CAP))) &&
                    ($signed(out_tdata[2*PWR_W-1:PWR_W]) <= $signed(PWR_W'(POWER_CAP)))))
    else $error("motor power above cap");

endmodule

bind joystick_setpoint_position_hold jsph_checker #(.POT_BITS(POT_BITS)) u_jsph_checker (.*);
